### design/adll_pkg.sv
// Package for the array doubly linked list core: sizes, request and status
// codes, item structs. No dependencies.
package adll_pkg;
  localparam int SLOTS = 32;
  localparam int DATA_WIDTH = 64;
  localparam int SW = $clog2(SLOTS);
  localparam int LW = $clog2(SLOTS + 1);
  localparam logic [LW-1:0] NONE = LW'(SLOTS);

  localparam logic [2:0] REQ_ADD_FIRST = 3'd0;
  localparam logic [2:0] REQ_ADD_AFTER = 3'd1;
  localparam logic [2:0] REQ_ADD_LAST  = 3'd2;
  localparam logic [2:0] REQ_DEL_FIRST = 3'd3;
  localparam logic [2:0] REQ_DEL_AFTER = 3'd4;
  localparam logic [2:0] REQ_DEL_LAST  = 3'd5;
  localparam logic [2:0] REQ_CLEAR     = 3'd6;
  localparam logic [2:0] REQ_WALK      = 3'd7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_POS   = 2'd3;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [4:0]  position;
    logic        walk_reverse;
    logic [63:0] entry_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  slot;
    logic [63:0] entry_out;
    logic [5:0]  entry_count;
    logic [5:0]  head_slot;
    logic [5:0]  tail_slot;
    logic        last;
  } out_item_t;
endpackage

### design/adll_front.sv
// Front part: two-entry request queue between the input channel and the
// list engine. Uses adll_pkg.
module adll_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  adll_pkg::in_item_t in_item,
  output logic               q_valid,
  input  logic               q_take,
  output adll_pkg::in_item_t q_item
);
  adll_pkg::in_item_t mem [2];
  logic rd, wr;
  logic [1:0] fill;
  logic push;

  assign in_stall = fill[1];
  assign push = in_valid && !in_stall;
  assign q_valid = fill != 2'd0;
  assign q_item = mem[rd];

  always_ff @(posedge clk) begin
    if (push) mem[wr] <= in_item;
    if (rst) begin
      rd <= 1'b0;
      wr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wr <= ~wr;
      if (q_take && q_valid) rd <= ~rd;
      fill <= fill + 2'(push) - 2'(q_take && q_valid);
    end
  end
endmodule

### design/adll_back.sv
// Back part: list engine with link and payload memories and a sequencer.
// Uses adll_pkg.
module adll_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_take,
  input  adll_pkg::in_item_t  q_item,
  output logic                out_valid,
  input  logic                out_stall,
  output adll_pkg::out_item_t out_item
);
  localparam int SW = adll_pkg::SW;
  localparam int LW = adll_pkg::LW;
  localparam logic [2:0] S_IDLE = 3'd0, S_RD = 3'd1, S_WR = 3'd2,
                         S_WALK = 3'd3, S_OUT = 3'd4, S_WRD = 3'd5;

  logic [LW-1:0] nxt [adll_pkg::SLOTS];
  logic [LW-1:0] prv [adll_pkg::SLOTS];
  logic [adll_pkg::DATA_WIDTH-1:0] pay [adll_pkg::SLOTS];
  logic [adll_pkg::SLOTS-1:0] used;
  logic [LW-1:0] head, tail, count;
  logic [2:0] state;
  adll_pkg::in_item_t req;
  logic [LW-1:0] s, p, n, walk_k;
  logic [SW-1:0] free;
  logic free_none;

  // lowest free slot: priority encoder over the valid bits
  always_comb begin
    free = '0;
    free_none = 1'b1;
    for (int i = adll_pkg::SLOTS - 1; i >= 0; i--)
      if (!used[i]) begin
        free = SW'(i);
        free_none = 1'b0;
      end
  end

  // take a request only once the result register is free or leaving
  assign q_take = state == S_IDLE && q_valid && (!out_valid || !out_stall);

  function automatic logic [5:0] w6(input logic [LW-1:0] v);
    return 6'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used <= '0;
      head <= adll_pkg::NONE;
      tail <= adll_pkg::NONE;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_WALK && state != S_OUT)
        out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (q_take) begin
          req <= q_item;
          state <= S_RD;
        end
        S_RD: begin
          // classify, latch link reads
          out_item.entry_out <= '0;
          out_item.slot <= '0;
          out_item.last <= 1'b1;
          state <= S_OUT;
          if (req.req_type == adll_pkg::REQ_ADD_FIRST ||
              req.req_type == adll_pkg::REQ_ADD_AFTER ||
              req.req_type == adll_pkg::REQ_ADD_LAST) begin
            if (free_none) out_item.status <= adll_pkg::ST_FULL;
            else if (req.req_type == adll_pkg::REQ_ADD_AFTER &&
                     !used[req.position[SW-1:0]])
              out_item.status <= adll_pkg::ST_POS;
            else begin
              s <= LW'(free);
              if (req.req_type == adll_pkg::REQ_ADD_FIRST || head == adll_pkg::NONE) begin
                p <= adll_pkg::NONE;
                n <= head;
              end else if (req.req_type == adll_pkg::REQ_ADD_AFTER) begin
                p <= LW'(req.position[SW-1:0]);
                n <= nxt[req.position[SW-1:0]];
              end else begin
                p <= tail;
                n <= adll_pkg::NONE;
              end
              state <= S_WR;
            end
          end else if (req.req_type == adll_pkg::REQ_CLEAR) begin
            used <= '0;
            head <= adll_pkg::NONE;
            tail <= adll_pkg::NONE;
            count <= '0;
            out_item.status <= adll_pkg::ST_OK;
            out_item.entry_count <= '0;
            out_item.head_slot <= w6(adll_pkg::NONE);
            out_item.tail_slot <= w6(adll_pkg::NONE);
          end else if (count == '0) begin
            out_item.status <= adll_pkg::ST_EMPTY;
          end else if (req.req_type == adll_pkg::REQ_WALK) begin
            s <= req.walk_reverse ? tail : head;
            walk_k <= '0;
            state <= S_WALK;
          end else begin
            if (req.req_type == adll_pkg::REQ_DEL_FIRST) begin
              s <= head;
              state <= S_WRD;
            end else if (req.req_type == adll_pkg::REQ_DEL_LAST) begin
              s <= tail;
              state <= S_WRD;
            end else if (!used[req.position[SW-1:0]] ||
                         nxt[req.position[SW-1:0]] == adll_pkg::NONE)
              out_item.status <= adll_pkg::ST_POS;
            else begin
              s <= nxt[req.position[SW-1:0]];
              state <= S_WRD;
            end
          end
          if (!(req.req_type == adll_pkg::REQ_CLEAR)) begin
            out_item.entry_count <= w6(count);
            out_item.head_slot <= w6(head);
            out_item.tail_slot <= w6(tail);
          end
        end
        S_WR: begin
          // link new slot s between p and n
          used[s[SW-1:0]] <= 1'b1;
          pay[s[SW-1:0]] <= req.entry_data[adll_pkg::DATA_WIDTH-1:0];
          prv[s[SW-1:0]] <= p;
          nxt[s[SW-1:0]] <= n;
          if (p == adll_pkg::NONE) head <= s; else nxt[p[SW-1:0]] <= s;
          if (n == adll_pkg::NONE) tail <= s; else prv[n[SW-1:0]] <= s;
          count <= count + 1'b1;
          out_item.status <= adll_pkg::ST_OK;
          out_item.slot <= 5'(s);
          out_item.entry_count <= w6(count + 1'b1);
          out_item.head_slot <= w6(p == adll_pkg::NONE ? s : head);
          out_item.tail_slot <= w6(n == adll_pkg::NONE ? s : tail);
          state <= S_OUT;
        end
        S_WRD: begin
          // unlink slot s
          if (prv[s[SW-1:0]] == adll_pkg::NONE) head <= nxt[s[SW-1:0]];
          else nxt[prv[s[SW-1:0]][SW-1:0]] <= nxt[s[SW-1:0]];
          if (nxt[s[SW-1:0]] == adll_pkg::NONE) tail <= prv[s[SW-1:0]];
          else prv[nxt[s[SW-1:0]][SW-1:0]] <= prv[s[SW-1:0]];
          used[s[SW-1:0]] <= 1'b0;
          count <= count - 1'b1;
          out_item.status <= adll_pkg::ST_OK;
          out_item.slot <= 5'(s);
          out_item.entry_count <= w6(count - 1'b1);
          out_item.head_slot <= w6(prv[s[SW-1:0]] == adll_pkg::NONE ?
                                   nxt[s[SW-1:0]] : head);
          out_item.tail_slot <= w6(nxt[s[SW-1:0]] == adll_pkg::NONE ?
                                   prv[s[SW-1:0]] : tail);
          state <= S_OUT;
        end
        S_WALK: if (!out_valid || !out_stall) begin
          // one visited entry per cycle while the output is not stalled
          out_valid <= 1'b1;
          out_item.status <= adll_pkg::ST_OK;
          out_item.slot <= 5'(s);
          out_item.entry_out <= 64'(pay[s[SW-1:0]]);
          out_item.entry_count <= w6(count);
          out_item.head_slot <= w6(head);
          out_item.tail_slot <= w6(tail);
          if ((req.walk_reverse ? prv[s[SW-1:0]] : nxt[s[SW-1:0]]) == adll_pkg::NONE ||
              walk_k + 1'b1 == count) begin
            out_item.last <= 1'b1;
            state <= S_IDLE;
          end else out_item.last <= 1'b0;
          s <= req.walk_reverse ? prv[s[SW-1:0]] : nxt[s[SW-1:0]];
          walk_k <= walk_k + 1'b1;
        end
        S_OUT: if (!out_valid || !out_stall) begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### design/array_doubly_linked_list_core.sv
// Top level of the array doubly linked list core.
// Depends on adll_pkg, adll_front, adll_back.
//
// Usage:
//  in channel (in_valid/in_stall/in_item) takes requests: add first, add
//  after, add last, delete first, delete after, delete tail, clear, walk.
//  out channel (out_valid/out_stall/out_item) gives result items.
//  An item is moved when valid is high and stall low at a clock edge.
//  Each update gives one status item with last set; a walk gives one item
//  per entry visited, last set on the final one.
//  Steps from accept to result for updates: queue, read and classify, link
//  write (skipped on errors), output register; walks then give one item per
//  cycle while out stall is low. The single sequencer of the back end sets
//  the rate: one request at a time, the next waits until the last is done.
//  A two-entry queue in front takes requests while the back end works.
//  Reset (rst, synchronous) empties the list and the queue; slot valid bits
//  clear at once, no clearing pass. Out stall holds the result register and
//  the sequencer; the front queue keeps accepting until full.
module array_doubly_linked_list_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  adll_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output adll_pkg::out_item_t out_item
);
  logic q_valid, q_take;
  adll_pkg::in_item_t q_item;

  adll_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_item,
    .q_valid, .q_take, .q_item
  );

  adll_back u_back (
    .clk, .rst, .q_valid, .q_take, .q_item,
    .out_valid, .out_stall, .out_item
  );
endmodule

### design/adll_checker.sv
// Port-level checker for the list core, bound to the top level.
// Depends on adll_pkg.
module adll_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input adll_pkg::out_item_t out_item
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("out item changed under stall");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.entry_count <= 6'd32)
    else $error("count out of range");
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.entry_count == 6'd0 |->
      out_item.head_slot == 6'd32 && out_item.tail_slot == 6'd32)
    else $error("empty list with head or tail");
  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status != adll_pkg::ST_OK |->
      out_item.last && out_item.slot == 5'd0)
    else $error("error item malformed");
  a_stall_known: assert property (@(posedge clk) disable iff (rst)
    in_valid |-> !$isunknown(in_stall))
    else $error("in stall unknown");
endmodule

bind array_doubly_linked_list_core adll_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .out_item
);

### test/tb.sv
// Testbench for array_doubly_linked_list_core: directed and random list requests,
// a local model of the slot array predicts every result item. Depends on adll_pkg.
`timescale 1ns / 1ps
module tb;
  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  adll_pkg::in_item_t in_item;
  logic out_valid;
  logic out_stall;
  adll_pkg::out_item_t out_item;

  array_doubly_linked_list_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  // Local copy of the list: slot array with prev/next links
  logic            lst_used [adll_pkg::SLOTS];
  logic [5:0]      lst_next [adll_pkg::SLOTS];
  logic [5:0]      lst_prev [adll_pkg::SLOTS];
  logic [63:0]     lst_data [adll_pkg::SLOTS];
  logic [5:0]      lst_head;
  logic [5:0]      lst_tail;
  logic [5:0]      lst_count;

  adll_pkg::in_item_t  pending_reqs[$];
  adll_pkg::out_item_t expected_items[$];
  bit        failed;
  bit        stim_done;
  int        cycles;
  int        in_gap;
  int        out_gap;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Pick a gap length: mostly zero or short, sometimes long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic adll_pkg::out_item_t status_item(logic [1:0] st, logic [4:0] s);
    adll_pkg::out_item_t o;
    o.status = st;
    o.slot = s;
    o.entry_out = '0;
    o.entry_count = lst_count;
    o.head_slot = lst_head;
    o.tail_slot = lst_tail;
    o.last = 1'b1;
    return o;
  endfunction

  function automatic logic [5:0] grab_slot(logic [63:0] d);
    int i;
    for (i = 0; i < adll_pkg::SLOTS; i++) begin
      if (!lst_used[i]) break;
    end
    lst_used[i] = 1'b1;
    lst_data[i] = d;
    lst_count++;
    return 6'(i);
  endfunction

  function automatic void unlink(logic [5:0] s);
    logic [5:0] p;
    logic [5:0] n;
    p = lst_prev[s[4:0]];
    n = lst_next[s[4:0]];
    if (p == adll_pkg::NONE) lst_head = n;
    else lst_next[p[4:0]] = n;
    if (n == adll_pkg::NONE) lst_tail = p;
    else lst_prev[n[4:0]] = p;
    lst_used[s[4:0]] = 1'b0;
    lst_count--;
  endfunction

  // Apply one request to the local list and queue the items it causes
  function automatic void predict_list(adll_pkg::in_item_t r);
    logic [5:0] s;
    logic [5:0] p;
    logic [5:0] n;
    logic       pos_ok;
    int         k;
    pos_ok = lst_used[r.position];
    case (r.req_type)
      adll_pkg::REQ_ADD_FIRST, adll_pkg::REQ_ADD_AFTER, adll_pkg::REQ_ADD_LAST: begin
        if (lst_count >= adll_pkg::SLOTS) begin
          expected_items.push_back(status_item(adll_pkg::ST_FULL, 5'd0));
        end else if (r.req_type == adll_pkg::REQ_ADD_AFTER && !pos_ok) begin
          expected_items.push_back(status_item(adll_pkg::ST_POS, 5'd0));
        end else begin
          s = grab_slot(r.entry_data);
          if (r.req_type == adll_pkg::REQ_ADD_FIRST || lst_head == adll_pkg::NONE) begin
            lst_prev[s[4:0]] = adll_pkg::NONE;
            lst_next[s[4:0]] = lst_head;
            if (lst_head == adll_pkg::NONE) lst_tail = s;
            else lst_prev[lst_head[4:0]] = s;
            lst_head = s;
          end else begin
            p = (r.req_type == adll_pkg::REQ_ADD_AFTER) ? 6'(r.position) : lst_tail;
            n = lst_next[p[4:0]];
            lst_prev[s[4:0]] = p;
            lst_next[s[4:0]] = n;
            lst_next[p[4:0]] = s;
            if (n == adll_pkg::NONE) lst_tail = s;
            else lst_prev[n[4:0]] = s;
          end
          expected_items.push_back(status_item(adll_pkg::ST_OK, s[4:0]));
        end
      end
      adll_pkg::REQ_DEL_FIRST, adll_pkg::REQ_DEL_AFTER, adll_pkg::REQ_DEL_LAST: begin
        if (lst_count == 0) begin
          expected_items.push_back(status_item(adll_pkg::ST_EMPTY, 5'd0));
        end else if (r.req_type == adll_pkg::REQ_DEL_AFTER &&
                     (!pos_ok || lst_next[r.position] == adll_pkg::NONE)) begin
          expected_items.push_back(status_item(adll_pkg::ST_POS, 5'd0));
        end else begin
          if (r.req_type == adll_pkg::REQ_DEL_FIRST) s = lst_head;
          else if (r.req_type == adll_pkg::REQ_DEL_LAST) s = lst_tail;
          else s = lst_next[r.position];
          unlink(s);
          expected_items.push_back(status_item(adll_pkg::ST_OK, s[4:0]));
        end
      end
      adll_pkg::REQ_CLEAR: begin
        foreach (lst_used[i]) lst_used[i] = 1'b0;
        lst_head = adll_pkg::NONE;
        lst_tail = adll_pkg::NONE;
        lst_count = '0;
        expected_items.push_back(status_item(adll_pkg::ST_OK, 5'd0));
      end
      default: begin
        if (lst_count == 0) begin
          expected_items.push_back(status_item(adll_pkg::ST_EMPTY, 5'd0));
        end else begin
          s = r.walk_reverse ? lst_tail : lst_head;
          k = 0;
          while (s != adll_pkg::NONE && k < adll_pkg::SLOTS && k < lst_count) begin
            adll_pkg::out_item_t o;
            n = r.walk_reverse ? lst_prev[s[4:0]] : lst_next[s[4:0]];
            o = status_item(adll_pkg::ST_OK, s[4:0]);
            o.entry_out = lst_data[s[4:0]];
            o.last = (n == adll_pkg::NONE) || (k + 1 == adll_pkg::SLOTS) ||
                     (k + 1 == lst_count);
            expected_items.push_back(o);
            k++;
            s = n;
          end
        end
      end
    endcase
  endfunction

  function automatic adll_pkg::in_item_t make_req(logic [2:0] t, logic [4:0] p, logic rv,
                                                  logic [63:0] d);
    adll_pkg::in_item_t r;
    r.req_type = t;
    r.position = p;
    r.walk_reverse = rv;
    r.entry_data = d;
    return r;
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // Random request; adds are favored when fill_bias is high so the list often fills up.
  // Positions lean toward slots near the low end, which are usually in use.
  function automatic adll_pkg::in_item_t rand_req(int fill_bias);
    int r;
    logic [2:0] t;
    r = $urandom_range(0, 99);
    if (r < fill_bias) t = 3'($urandom_range(0, 2));
    else if (r < 90) t = 3'($urandom_range(3, 5));
    else if (r < 93) t = adll_pkg::REQ_CLEAR;
    else t = adll_pkg::REQ_WALK;
    return make_req(t, ($urandom_range(0, 3) == 0) ? 5'($urandom()) :
                    5'($urandom_range(0, 12)), 1'($urandom()), rand_word());
  endfunction

  initial begin
    int i;
    // Directed part: empty cases, extremes, every request type
    pending_reqs.push_back(make_req(adll_pkg::REQ_WALK, 5'd0, 1'b0, 64'd0));
    pending_reqs.push_back(make_req(adll_pkg::REQ_DEL_FIRST, 5'd0, 1'b0, 64'd0));
    pending_reqs.push_back(make_req(adll_pkg::REQ_DEL_AFTER, 5'd0, 1'b0, 64'd0));
    pending_reqs.push_back(make_req(adll_pkg::REQ_DEL_LAST, 5'd0, 1'b0, 64'd0));
    pending_reqs.push_back(make_req(adll_pkg::REQ_ADD_AFTER, 5'd31, 1'b0, 64'h1));
    pending_reqs.push_back(make_req(adll_pkg::REQ_ADD_LAST, 5'd0, 1'b0, '1));
    pending_reqs.push_back(make_req(adll_pkg::REQ_ADD_FIRST, 5'd0, 1'b0, '0));
    pending_reqs.push_back(make_req(adll_pkg::REQ_ADD_AFTER, 5'd0, 1'b1,
                                    64'hA5A5_5A5A_F0F0_0F0F));
    pending_reqs.push_back(make_req(adll_pkg::REQ_ADD_AFTER, 5'd31, 1'b0, 64'h2));
    pending_reqs.push_back(make_req(adll_pkg::REQ_DEL_AFTER, 5'd0, 1'b0, 64'd0));
    pending_reqs.push_back(make_req(adll_pkg::REQ_DEL_AFTER, 5'd31, 1'b0, 64'd0));
    pending_reqs.push_back(make_req(adll_pkg::REQ_WALK, 5'd0, 1'b0, 64'd0));
    pending_reqs.push_back(make_req(adll_pkg::REQ_WALK, 5'd31, 1'b1, '1));
    pending_reqs.push_back(make_req(adll_pkg::REQ_DEL_AFTER, 5'd1, 1'b0, 64'd0));
    pending_reqs.push_back(make_req(adll_pkg::REQ_DEL_LAST, 5'd0, 1'b0, 64'd0));
    pending_reqs.push_back(make_req(adll_pkg::REQ_DEL_FIRST, 5'd0, 1'b0, 64'd0));
    pending_reqs.push_back(make_req(adll_pkg::REQ_CLEAR, 5'd31, 1'b1, '1));
    // Fill to full, overflow, walk a full list both ways, add after slot 31
    for (i = 0; i < adll_pkg::SLOTS; i++)
      pending_reqs.push_back(make_req(adll_pkg::REQ_ADD_LAST, 5'd0, 1'b0, rand_word()));
    pending_reqs.push_back(make_req(adll_pkg::REQ_ADD_FIRST, 5'd0, 1'b0, rand_word()));
    pending_reqs.push_back(make_req(adll_pkg::REQ_ADD_AFTER, 5'd31, 1'b0, rand_word()));
    pending_reqs.push_back(make_req(adll_pkg::REQ_WALK, 5'd0, 1'b0, 64'd0));
    pending_reqs.push_back(make_req(adll_pkg::REQ_WALK, 5'd0, 1'b1, 64'd0));
    pending_reqs.push_back(make_req(adll_pkg::REQ_DEL_AFTER, 5'd31, 1'b0, 64'd0));
    pending_reqs.push_back(make_req(adll_pkg::REQ_CLEAR, 5'd0, 1'b0, 64'd0));
    // Random part in phases of growing and shrinking lists
    for (i = 0; i < 170; i++) begin
      pending_reqs.push_back(rand_req(((i / 40) % 2 == 0) ? 65 : 30));
      if ($urandom_range(0, 14) == 0)
        pending_reqs.push_back(make_req(adll_pkg::REQ_WALK, 5'($urandom()),
                                        1'($urandom()), rand_word()));
    end
  end

  // Driver: present the next request; hold it while stalled
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_item <= '0;
      in_gap <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) predict_list(in_item);
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_reqs.size() > 0) begin
        in_valid <= 1'b1;
        in_item <= pending_reqs.pop_front();
        in_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  // Monitor: compare each result item with the oldest expectation
  always @(posedge clk) begin
    adll_pkg::out_item_t e;
    if (rst) begin
      out_stall <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_items.size() == 0) begin
          $display("%0t: unexpected result item %p", $time, out_item);
          failed = 1'b1;
        end else begin
          e = expected_items.pop_front();
          if (out_item !== e) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, out_item);
            failed = 1'b1;
          end
        end
      end
      if (out_gap > 0) begin
        out_stall <= 1'b1;
        out_gap <= out_gap - 1;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 5) == 0) out_gap <= pick_gap();
      end
    end
  end

  initial begin
    int drain;
    lst_head = adll_pkg::NONE;
    lst_tail = adll_pkg::NONE;
    lst_count = '0;
    foreach (lst_used[i]) lst_used[i] = 1'b0;
    failed = 1'b0;
    stim_done = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    wait (stim_done && expected_items.size() == 0);
    // let any stray item show up
    drain = 0;
    while (drain < 200) begin
      @(posedge clk);
      drain++;
    end
    if (!failed && expected_items.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Generous cycle limit
  initial begin
    cycles = 0;
    while (cycles < 2000000) begin
      @(posedge clk);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end
endmodule

### sim.f
design/adll_pkg.sv
design/adll_front.sv
design/adll_back.sv
design/array_doubly_linked_list_core.sv
design/adll_checker.sv
test/tb.sv
